### rtl/skn_pkg.sv
package skn_pkg;

    localparam int BONE_W    = 8;
    localparam int IN_W      = 16;
    localparam int WEIGHT_W  = 20;
    localparam int SHARE_W   = 16;
    localparam int TOTAL_W   = 22;
    localparam int QUOT_W    = 17;
    localparam int CNT_W     = 5;
    localparam int COUNT_W   = 3;
    localparam int OUT_SLOTS = 4;
    localparam int OUT_W     = 104;

    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = '1;
    localparam logic [SHARE_W-1:0]  SHARE_MAX  = '1;

    // one table entry as it moves along the chain
    typedef struct packed {
        logic                vld;
        logic [BONE_W-1:0]   bone;
        logic [WEIGHT_W-1:0] weight;
    } skn_entry_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_ACC,
        CELL_SHIFT
    } skn_cell_op_t;

    // control shared by every cell of the chain
    typedef struct packed {
        skn_cell_op_t op;
        logic         any_match;
    } skn_cell_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DRAIN,
        ST_SUM,
        ST_SHARE,
        ST_DIV_WAIT,
        ST_FINISH
    } skn_state_t;

    // equal split of one when all kept weights are zero
    function automatic logic [SHARE_W-1:0] eq_share(input logic [COUNT_W-1:0] n);
        logic [SHARE_W-1:0] s;
        case (n)
            3'd1:    s = SHARE_MAX;
            3'd2:    s = 16'd32768;
            3'd3:    s = 16'd21845;
            3'd4:    s = 16'd16384;
            default: s = '0;
        endcase
        return s;
    endfunction

endpackage

### rtl/skn_cell.sv
module skn_cell (
    input  logic                         clk,
    input  logic                         rst_n,
    input  skn_pkg::skn_cell_ctl_t       ctl,
    input  logic [skn_pkg::BONE_W-1:0]   pair_bone,
    input  logic [skn_pkg::IN_W-1:0]     pair_weight,
    input  logic                         prev_vld,
    input  skn_pkg::skn_entry_t          nxt,
    output skn_pkg::skn_entry_t          cur,
    output logic                         match
);

    logic                           vld_reg, vld_next;
    logic [skn_pkg::BONE_W-1:0]     bone_reg, bone_next;
    logic [skn_pkg::WEIGHT_W-1:0]   weight_reg, weight_next;
    logic [skn_pkg::WEIGHT_W:0]     sum;
    logic [skn_pkg::WEIGHT_W-1:0]   sat;

    assign match = vld_reg && (bone_reg == pair_bone);
    assign cur   = '{vld: vld_reg, bone: bone_reg, weight: weight_reg};

    // saturating accumulate of a repeated bone
    assign sum = {1'b0, weight_reg} + {{(skn_pkg::WEIGHT_W + 1 - skn_pkg::IN_W){1'b0}}, pair_weight};
    assign sat = sum[skn_pkg::WEIGHT_W] ? skn_pkg::WEIGHT_MAX : sum[skn_pkg::WEIGHT_W-1:0];

    // accumulate, append at the first free cell, or take the neighbor's entry
    always_comb
    begin
        vld_next    = vld_reg;
        bone_next   = bone_reg;
        weight_next = weight_reg;
        case (ctl.op)
            skn_pkg::CELL_ACC:
            begin
                if (match)
                begin
                    weight_next = sat;
                end
                else if (!ctl.any_match && !vld_reg && prev_vld)
                begin
                    vld_next    = 1'b1;
                    bone_next   = pair_bone;
                    weight_next = {{(skn_pkg::WEIGHT_W - skn_pkg::IN_W){1'b0}}, pair_weight};
                end
            end
            skn_pkg::CELL_SHIFT:
            begin
                vld_next    = nxt.vld;
                bone_next   = nxt.bone;
                weight_next = nxt.weight;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bone_reg   <= bone_next;
        weight_reg <= weight_next;
    end

endmodule

### rtl/skn_keep.sv
module skn_keep #(
    parameter int KEEP = 4
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     clear,
    input  logic                                     push,
    input  logic [skn_pkg::BONE_W-1:0]               push_bone,
    input  logic [skn_pkg::WEIGHT_W-1:0]             push_weight,
    output logic [$clog2(KEEP+1)-1:0]                count,
    output logic [KEEP-1:0][skn_pkg::BONE_W-1:0]     bones,
    output logic [KEEP-1:0][skn_pkg::WEIGHT_W-1:0]   weights
);

    localparam int CW = $clog2(KEEP + 1);
    localparam int IW = (KEEP > 1) ? $clog2(KEEP) : 1;

    logic [CW-1:0]                             count_reg, count_next;
    logic [KEEP-1:0][skn_pkg::BONE_W-1:0]      bones_reg, bones_next;
    logic [KEEP-1:0][skn_pkg::WEIGHT_W-1:0]    weights_reg, weights_next;
    logic [skn_pkg::WEIGHT_W-1:0]              min_w;
    logic [IW-1:0]                             min_pos;

    assign count   = count_reg;
    assign bones   = bones_reg;
    assign weights = weights_reg;

    // first smallest weight among all KEEP slots
    always_comb
    begin
        min_w   = weights_reg[0];
        min_pos = '0;
        for (int j = 1; j < KEEP; j++)
        begin
            if (weights_reg[j] < min_w)
            begin
                min_w   = weights_reg[j];
                min_pos = IW'(j);
            end
        end
    end

    // clear empties the buffer; else append while room is left, else evict the first
    // smallest if the newcomer is not smaller; a later entry wins ties
    always_comb
    begin
        count_next   = count_reg;
        bones_next   = bones_reg;
        weights_next = weights_reg;
        if (clear)
        begin
            count_next = '0;
        end
        else if (push)
        begin
            if (count_reg < CW'(KEEP))
            begin
                for (int j = 0; j < KEEP; j++)
                begin
                    if (CW'(j) == count_reg)
                    begin
                        bones_next[j]   = push_bone;
                        weights_next[j] = push_weight;
                    end
                end
                count_next = count_reg + 1'b1;
            end
            else if (push_weight >= min_w)
            begin
                for (int j = 0; j < KEEP - 1; j++)
                begin
                    if (IW'(j) >= min_pos)
                    begin
                        bones_next[j]   = bones_reg[j+1];
                        weights_next[j] = weights_reg[j+1];
                    end
                end
                bones_next[KEEP-1]   = push_bone;
                weights_next[KEEP-1] = push_weight;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bones_reg   <= bones_next;
        weights_reg <= weights_next;
    end

endmodule

### rtl/skn_div.sv
module skn_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [skn_pkg::WEIGHT_W-1:0]   num_weight,
    input  logic [skn_pkg::TOTAL_W-1:0]    total,
    output logic                           done,
    output logic [skn_pkg::SHARE_W-1:0]    share
);

    localparam int NUM_W = skn_pkg::WEIGHT_W + skn_pkg::IN_W + 1;

    logic                           busy_reg;
    logic                           done_reg;
    logic [skn_pkg::CNT_W-1:0]      cnt_reg;
    logic [skn_pkg::TOTAL_W-1:0]    rem_reg;
    logic [skn_pkg::TOTAL_W-1:0]    div_reg;
    logic [skn_pkg::QUOT_W-1:0]     low_reg;
    logic [skn_pkg::QUOT_W-1:0]     quot_reg;
    logic [NUM_W-1:0]               numer;
    logic [skn_pkg::TOTAL_W:0]      trial;
    logic [skn_pkg::TOTAL_W:0]      diff;
    logic                           ge;

    // w * 65536 + total / 2, rounding half up
    assign numer = {1'b0, num_weight, {skn_pkg::IN_W{1'b0}}}
                 + {{(NUM_W - skn_pkg::TOTAL_W + 1){1'b0}}, total[skn_pkg::TOTAL_W-1:1]};

    // one restoring step per cycle
    assign trial = {rem_reg, low_reg[skn_pkg::QUOT_W-1]};
    assign ge    = trial >= {1'b0, div_reg};
    assign diff  = trial - {1'b0, div_reg};

    assign done  = done_reg;
    assign share = quot_reg[skn_pkg::QUOT_W-1] ? skn_pkg::SHARE_MAX
                                                : quot_reg[skn_pkg::SHARE_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= skn_pkg::CNT_W'(skn_pkg::QUOT_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == skn_pkg::CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= {{(skn_pkg::TOTAL_W - (NUM_W - skn_pkg::QUOT_W)){1'b0}},
                         numer[NUM_W-1:skn_pkg::QUOT_W]};
            low_reg  <= numer[skn_pkg::QUOT_W-1:0];
            div_reg  <= total;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= ge ? diff[skn_pkg::TOTAL_W-1:0] : trial[skn_pkg::TOTAL_W-1:0];
            low_reg  <= {low_reg[skn_pkg::QUOT_W-2:0], 1'b0};
            quot_reg <= {quot_reg[skn_pkg::QUOT_W-2:0], ge};
        end
    end

endmodule

### rtl/skin_influence_top4_normalizer_core.sv
// Skin influence selector: collects the (bone, weight) pairs of one vertex,
// keeps the strongest KEEP_COUNT bones and normalizes their weights to sum one.
// s_* : one pair per item, tlast marks the last pair of the vertex.
// m_* : one result item per vertex, bones and Q0.16 shares in insertion order.
// cfg_*: write of the prune threshold, always ready; the user must write it
// only while idle, the block itself does not enforce it. Pairs are taken one
// per cycle while idle; each pair is matched against all held bones at once
// by a chain of TABLE_DEPTH cells and added or appended in that cycle.
// After the last pair the input stalls while the chain shifts its entries
// out through a top-k buffer, the kept weights are summed and each kept
// share is divided by a one-bit-per-cycle divider (or set to an equal split
// when the kept total is zero), then the result is loaded.
// The result sits in an output register; if the receiver stalls, new pairs
// are still taken and only the next vertex's finish waits for the slot.
// Reset empties the table, clears the overflow flag and the output valid,
// and sets the threshold to zero.
module skin_influence_top4_normalizer_core #(
    parameter int TABLE_DEPTH = 16,
    parameter int KEEP_COUNT  = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [skn_pkg::IN_W-1:0]      cfg_data,     // prune_threshold
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [23:0]                   s_tdata,      // bone_index, weight
    input  logic                          s_tlast,      // last
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // influence_count, bone_a, bone_b, bone_c, bone_d,
    // share_a, share_b, share_c, share_d, zero fill
    output logic [skn_pkg::OUT_W-1:0]     m_tdata,
    output logic                          m_tuser       // table_overflow
);

    localparam int CW = $clog2(KEEP_COUNT + 1);

    skn_pkg::skn_state_t                              state_reg, state_next;
    skn_pkg::skn_cell_ctl_t                           ctl;
    skn_pkg::skn_entry_t                              ent      [TABLE_DEPTH];
    skn_pkg::skn_entry_t                              nxt_ent  [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]                           prev_vld;
    logic [TABLE_DEPTH-1:0]                           match_vec;

    logic [skn_pkg::IN_W-1:0]                         thr_reg;
    logic                                             ovf_seen_reg, ovf_hold_reg;
    logic [skn_pkg::TOTAL_W-1:0]                      total_reg, total_sum;
    logic [CW-1:0]                                    slot_reg, slot_next;
    logic [KEEP_COUNT-1:0][skn_pkg::SHARE_W-1:0]      share_reg, share_next;

    logic                                             accept;
    logic                                             ovf_now;
    logic                                             keep_push, keep_clear;
    logic [CW-1:0]                                    keep_count;
    logic [KEEP_COUNT-1:0][skn_pkg::BONE_W-1:0]       keep_bones;
    logic [KEEP_COUNT-1:0][skn_pkg::WEIGHT_W-1:0]     keep_weights;

    logic                                             div_start, div_done;
    logic [skn_pkg::WEIGHT_W-1:0]                     div_weight;
    logic [skn_pkg::SHARE_W-1:0]                      div_share;
    logic                                             load_out;

    logic [skn_pkg::OUT_SLOTS-1:0][skn_pkg::BONE_W-1:0]  out_bones;
    logic [skn_pkg::OUT_SLOTS-1:0][skn_pkg::SHARE_W-1:0] out_shares;
    logic [skn_pkg::OUT_W-1:0]                        out_word;
    logic [skn_pkg::OUT_W-1:0]                        m_tdata_reg;
    logic                                             m_tvalid_reg, m_tuser_reg;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == skn_pkg::ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    // chain of table cells, entries move toward cell 0 while draining
    for (genvar g = 0; g < TABLE_DEPTH; g++)
    begin : g_chain
        if (g == 0)
        begin : g_head
            assign prev_vld[g] = 1'b1;
        end
        else
        begin : g_body
            assign prev_vld[g] = ent[g-1].vld;
        end
        if (g == TABLE_DEPTH - 1)
        begin : g_tail
            assign nxt_ent[g] = '0;
        end
        else
        begin : g_link
            assign nxt_ent[g] = ent[g+1];
        end

        skn_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .pair_bone   (s_tdata[7:0]),
            .pair_weight (s_tdata[23:8]),
            .prev_vld    (prev_vld[g]),
            .nxt         (nxt_ent[g]),
            .cur         (ent[g]),
            .match       (match_vec[g])
        );
    end

    // chain command
    always_comb
    begin
        ctl.any_match = |match_vec;
        ctl.op        = skn_pkg::CELL_HOLD;
        if (accept)
        begin
            ctl.op = skn_pkg::CELL_ACC;
        end
        else if (state_reg == skn_pkg::ST_DRAIN)
        begin
            ctl.op = skn_pkg::CELL_SHIFT;
        end
    end

    // new bone with the table full
    assign ovf_now = accept && !(|match_vec) && ent[TABLE_DEPTH-1].vld;

    // prune at the chain head, survivors go to the top-k buffer
    assign keep_push  = (state_reg == skn_pkg::ST_DRAIN) && ent[0].vld
                     && (ent[0].weight >= {{(skn_pkg::WEIGHT_W - skn_pkg::IN_W){1'b0}}, thr_reg});
    assign keep_clear = load_out;

    skn_keep #(
        .KEEP (KEEP_COUNT)
    ) u_keep (
        .clk         (clk),
        .rst_n       (rst_n),
        .clear       (keep_clear),
        .push        (keep_push),
        .push_bone   (ent[0].bone),
        .push_weight (ent[0].weight),
        .count       (keep_count),
        .bones       (keep_bones),
        .weights     (keep_weights)
    );

    // total of the kept weights and divider operand select
    always_comb
    begin
        total_sum  = '0;
        div_weight = '0;
        for (int j = 0; j < KEEP_COUNT; j++)
        begin
            if (CW'(j) < keep_count)
            begin
                total_sum = total_sum
                          + {{(skn_pkg::TOTAL_W - skn_pkg::WEIGHT_W){1'b0}}, keep_weights[j]};
            end
            if (CW'(j) == slot_reg)
            begin
                div_weight = keep_weights[j];
            end
        end
    end

    skn_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (div_start),
        .num_weight (div_weight),
        .total      (total_reg),
        .done       (div_done),
        .share      (div_share)
    );

    // finishing sequencer
    always_comb
    begin
        state_next = state_reg;
        slot_next  = slot_reg;
        share_next = share_reg;
        div_start  = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            skn_pkg::ST_IDLE:
            begin
                if (accept && s_tlast)
                begin
                    state_next = skn_pkg::ST_DRAIN;
                end
            end
            skn_pkg::ST_DRAIN:
            begin
                if (!ent[0].vld)
                begin
                    state_next = skn_pkg::ST_SUM;
                end
            end
            skn_pkg::ST_SUM:
            begin
                slot_next  = '0;
                state_next = skn_pkg::ST_SHARE;
            end
            skn_pkg::ST_SHARE:
            begin
                if (slot_reg == keep_count)
                begin
                    state_next = skn_pkg::ST_FINISH;
                end
                else if (total_reg == '0)
                begin
                    for (int j = 0; j < KEEP_COUNT; j++)
                    begin
                        if (CW'(j) == slot_reg)
                        begin
                            share_next[j] = skn_pkg::eq_share(skn_pkg::COUNT_W'(keep_count));
                        end
                    end
                    slot_next = slot_reg + 1'b1;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = skn_pkg::ST_DIV_WAIT;
                end
            end
            skn_pkg::ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    for (int j = 0; j < KEEP_COUNT; j++)
                    begin
                        if (CW'(j) == slot_reg)
                        begin
                            share_next[j] = div_share;
                        end
                    end
                    slot_next  = slot_reg + 1'b1;
                    state_next = skn_pkg::ST_SHARE;
                end
            end
            skn_pkg::ST_FINISH:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    load_out   = 1'b1;
                    state_next = skn_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = skn_pkg::ST_IDLE;
            end
        endcase
    end

    // result slots, zero beyond the kept count
    for (genvar g = 0; g < skn_pkg::OUT_SLOTS; g++)
    begin : g_slot
        if (g < KEEP_COUNT)
        begin : g_used
            assign out_bones[g]  = (CW'(g) < keep_count) ? keep_bones[g] : '0;
            assign out_shares[g] = (CW'(g) < keep_count) ? share_reg[g]  : '0;
        end
        else
        begin : g_unused
            assign out_bones[g]  = '0;
            assign out_shares[g] = '0;
        end
    end

    assign out_word = {5'b0, out_shares, out_bones, skn_pkg::COUNT_W'(keep_count)};

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= skn_pkg::ST_IDLE;
            thr_reg      <= '0;
            ovf_seen_reg <= 1'b0;
            ovf_hold_reg <= 1'b0;
            slot_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            slot_reg  <= slot_next;
            if (cfg_valid)
            begin
                thr_reg <= cfg_data;
            end
            if (accept)
            begin
                if (s_tlast)
                begin
                    ovf_hold_reg <= ovf_seen_reg | ovf_now;
                    ovf_seen_reg <= 1'b0;
                end
                else if (ovf_now)
                begin
                    ovf_seen_reg <= 1'b1;
                end
            end
            if (load_out)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        share_reg <= share_next;
        if (state_reg == skn_pkg::ST_SUM)
        begin
            total_reg <= total_sum;
        end
        if (load_out)
        begin
            m_tdata_reg <= out_word;
            m_tuser_reg <= ovf_hold_reg;
        end
    end

endmodule
